// File: hw/rtl/lcsr_pkg.sv
// Shared types, register codes and helpers for the load cell serial reader.
package lcsr_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_GAIN  = 2'd0;
   localparam logic [1:0] REG_HALF  = 2'd1;
   localparam logic [1:0] REG_AVG   = 2'd2;
   localparam logic [1:0] REG_SCALE = 2'd3;

   // Gain selector codes
   localparam logic [1:0] GAIN_A128 = 2'd0;
   localparam logic [1:0] GAIN_A64  = 2'd1;
   localparam logic [1:0] GAIN_B32  = 2'd2;

   // Reset values of the registers
   localparam logic [1:0]  RST_GAIN  = GAIN_A64;
   localparam logic [9:0]  RST_HALF  = 10'd8;
   localparam logic [7:0]  RST_AVG   = 8'd1;
   localparam logic [31:0] RST_SCALE = 32'd65536;

   // Result field widths and stream packing
   localparam int OUT_AVG_W  = 24;
   localparam int OUT_NET_W  = 25;
   localparam int OUT_WGT_W  = 41;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_PAD_W  = RSP_DATA_W - 1 - OUT_AVG_W - OUT_NET_W - OUT_WGT_W;

   // Saturation limits of the weight field
   localparam logic signed [OUT_WGT_W-1:0] WGT_MAX = {1'b0, {(OUT_WGT_W-1){1'b1}}};
   localparam logic signed [OUT_WGT_W-1:0] WGT_MIN = {1'b1, {(OUT_WGT_W-1){1'b0}}};

   // Control part of one queued job
   typedef struct packed {
      logic sck;       // serial clock level after this tick
      logic avg_done;  // this tick completes an average
      logic tare;      // store this average as the tare offset
   } lcsr_job_ctl_type;

   // Extra pulses after the data bits for each gain selector
   function automatic logic [1:0] extra_pulses(input logic [1:0] gain);
      logic [1:0] n;
      case (gain)
         GAIN_A64: n = 2'd3;
         GAIN_B32: n = 2'd2;
         default:  n = 2'd1;
      endcase
      return n;
   endfunction

endpackage

// File: hw/rtl/lcsr_queue.sv
// Two-entry job queue between the serial front end and the arithmetic back end.
module lcsr_queue #(
   parameter int WIDTH = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             in_ready,
   input  logic             pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/lcsr_front.sv
// Serial clock sequencer: waits for data low, shifts in bits, sums conversions.
module lcsr_front #(
   parameter int DATA_BITS = 24,
   parameter int SUM_W     = 32,
   parameter int PULSE_W   = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tick,        // item accepted this cycle
   input  logic                     kind,
   input  logic                     dout_level,
   input  logic [1:0]               gain_mode,
   input  logic [9:0]               half_period_ticks,
   input  logic [7:0]               average_count,
   output lcsr_pkg::lcsr_job_ctl_type job_ctl,
   output logic [SUM_W-1:0]         job_sum
);

   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [9:0]           tick_ff, tick_in;
   logic [PULSE_W-1:0]   pulse_ff, pulse_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [7:0]           rd_ff, rd_in;
   logic                 tare_ff, tare_in;

   logic [9:0]           hp_eff;
   logic [7:0]           cnt_eff;
   logic [10:0]          tick_inc;
   logic                 half_done;
   logic [PULSE_W-1:0]   pulse_total;
   logic [DATA_BITS-1:0] conv;
   logic [SUM_W-1:0]     sum_new;
   logic [8:0]           rd_inc;
   logic                 tare_eff;

   assign hp_eff      = (half_period_ticks == 10'd0) ? 10'd1 : half_period_ticks;
   assign cnt_eff     = (average_count == 8'd0) ? 8'd1 : average_count;
   assign tick_inc    = {1'b0, tick_ff} + 11'd1;
   assign half_done   = (tick_inc >= {1'b0, hp_eff});
   assign pulse_total = PULSE_W'(DATA_BITS) + PULSE_W'(lcsr_pkg::extra_pulses(gain_mode));
   assign conv        = shift_ff ^ {1'b1, {(DATA_BITS-1){1'b0}}};
   assign sum_new     = sum_ff + SUM_W'(conv);
   assign rd_inc      = {1'b0, rd_ff} + 9'd1;
   assign tare_eff    = tare_ff | kind;

   // Step the serial sequence for this tick
   always_comb begin
      phase_in         = phase_ff;
      tick_in          = tick_ff;
      pulse_in         = pulse_ff;
      shift_in         = shift_ff;
      sum_in           = sum_ff;
      rd_in            = rd_ff;
      tare_in          = tare_eff;
      job_ctl.avg_done = 1'b0;
      job_ctl.tare     = 1'b0;
      job_sum          = sum_new;
      case (phase_ff)
         PH_HIGH: begin
            tick_in = tick_inc[9:0];
            if (half_done) begin
               if (pulse_ff < PULSE_W'(DATA_BITS)) begin
                  shift_in = {shift_ff[DATA_BITS-2:0], dout_level};
               end
               pulse_in = pulse_ff + PULSE_W'(1);
               tick_in  = 10'd0;
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            tick_in = tick_inc[9:0];
            if (half_done) begin
               tick_in = 10'd0;
               if (pulse_ff >= pulse_total) begin
                  phase_in = PH_WAIT;
                  if (rd_inc >= {1'b0, cnt_eff}) begin
                     // Average complete: hand the sum to the back end
                     job_ctl.avg_done = 1'b1;
                     job_ctl.tare     = tare_eff;
                     tare_in          = 1'b0;
                     sum_in           = '0;
                     rd_in            = 8'd0;
                  end else begin
                     sum_in = sum_new;
                     rd_in  = rd_inc[7:0];
                  end
               end else begin
                  phase_in = PH_HIGH;
               end
            end
         end
         default: begin
            phase_in = PH_WAIT;
            if (!dout_level) begin
               phase_in = PH_HIGH;
               tick_in  = 10'd0;
               pulse_in = '0;
               shift_in = '0;
            end
         end
      endcase
      job_ctl.sck = (phase_in == PH_HIGH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         tick_ff  <= 10'd0;
         pulse_ff <= '0;
         shift_ff <= '0;
         sum_ff   <= '0;
         rd_ff    <= 8'd0;
         tare_ff  <= 1'b0;
      end else if (tick) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         pulse_ff <= pulse_in;
         shift_ff <= shift_in;
         sum_ff   <= sum_in;
         rd_ff    <= rd_in;
         tare_ff  <= tare_in;
      end
   end

endmodule

// File: hw/rtl/lcsr_back.sv
// Result engine: averages by serial division, applies tare, scales and saturates.
module lcsr_back #(
   parameter int DATA_BITS = 24,
   parameter int FRAC_BITS = 16,
   parameter int SUM_W     = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  lcsr_pkg::lcsr_job_ctl_type           job_ctl,
   input  logic [SUM_W-1:0]                   job_sum,
   output logic                               job_pop,
   input  logic [7:0]                         average_count,
   input  logic signed [31:0]                 scale_factor,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               out_sck,
   output logic                               out_result_valid,
   output logic [lcsr_pkg::OUT_AVG_W-1:0]     out_avg,
   output logic signed [lcsr_pkg::OUT_NET_W-1:0] out_net,
   output logic signed [lcsr_pkg::OUT_WGT_W-1:0] out_weight,
   output logic                               out_tare
);

   localparam int NET_W  = DATA_BITS + 1;
   localparam int PROD_W = NET_W + 32;
   localparam int EXT_W  = (PROD_W > lcsr_pkg::OUT_WGT_W) ? PROD_W : lcsr_pkg::OUT_WGT_W;
   localparam int CNT_W  = $clog2(SUM_W + 1);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_DIV  = 3'd1;
   localparam logic [2:0] B_NET  = 3'd2;
   localparam logic [2:0] B_MUL  = 3'd3;
   localparam logic [2:0] B_SAT  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         div_cnt_ff, div_cnt_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [7:0]               rem_ff, rem_in;
   logic                     tare_ff, tare_in;
   logic [DATA_BITS-1:0]     zero_ff, zero_in;
   logic [DATA_BITS-1:0]     avg_ff, avg_in;
   logic signed [NET_W-1:0]  net_ff, net_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic                     out_valid_ff, out_valid_in;
   logic                     out_sck_ff, out_sck_in;
   logic                     out_rv_ff, out_rv_in;
   logic [lcsr_pkg::OUT_AVG_W-1:0]        out_avg_ff, out_avg_in;
   logic signed [lcsr_pkg::OUT_NET_W-1:0] out_net_ff, out_net_in;
   logic signed [lcsr_pkg::OUT_WGT_W-1:0] out_wgt_ff, out_wgt_in;
   logic                     out_tare_ff, out_tare_in;

   logic                     out_free;
   logic [7:0]               cnt_eff;
   logic [8:0]               trial;
   logic                     trial_ge;
   logic [DATA_BITS-1:0]     avg_q;
   logic [DATA_BITS-1:0]     offset;
   logic signed [PROD_W-1:0] shifted;
   logic signed [EXT_W-1:0]  wide;
   logic signed [lcsr_pkg::OUT_WGT_W-1:0] wgt_sat;

   assign out_free = !out_valid_ff || out_ready;
   assign cnt_eff  = (average_count == 8'd0) ? 8'd1 : average_count;
   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge = (trial >= {1'b0, cnt_eff});
   assign avg_q    = quo_ff[DATA_BITS-1:0];
   assign offset   = tare_ff ? avg_q : zero_ff;
   assign shifted  = prod_ff >>> FRAC_BITS;
   assign wide     = EXT_W'(shifted);

   // Clamp the scaled value to the weight range
   always_comb begin
      if (wide > EXT_W'(lcsr_pkg::WGT_MAX)) begin
         wgt_sat = lcsr_pkg::WGT_MAX;
      end else if (wide < EXT_W'(lcsr_pkg::WGT_MIN)) begin
         wgt_sat = lcsr_pkg::WGT_MIN;
      end else begin
         wgt_sat = lcsr_pkg::OUT_WGT_W'(wide);
      end
   end

   // Sequence one job at a time
   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      tare_in      = tare_ff;
      zero_in      = zero_ff;
      avg_in       = avg_ff;
      net_in       = net_ff;
      prod_in      = prod_ff;
      job_pop      = 1'b0;
      out_valid_in = out_valid_ff && !out_ready;
      out_sck_in   = out_sck_ff;
      out_rv_in    = out_rv_ff;
      out_avg_in   = out_avg_ff;
      out_net_in   = out_net_ff;
      out_wgt_in   = out_wgt_ff;
      out_tare_in  = out_tare_ff;
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               if (!job_ctl.avg_done) begin
                  // Plain tick: pass the clock level straight out
                  if (out_free) begin
                     job_pop      = 1'b1;
                     out_valid_in = 1'b1;
                     out_sck_in   = job_ctl.sck;
                     out_rv_in    = 1'b0;
                     out_avg_in   = '0;
                     out_net_in   = '0;
                     out_wgt_in   = '0;
                     out_tare_in  = 1'b0;
                  end
               end else begin
                  job_pop    = 1'b1;
                  out_sck_in = out_sck_ff;
                  quo_in     = job_sum;
                  rem_in     = 8'd0;
                  div_cnt_in = CNT_W'(SUM_W);
                  tare_in    = job_ctl.tare;
                  state_in   = B_DIV;
               end
            end
         end
         B_DIV: begin
            // One quotient bit per cycle
            if (trial_ge) begin
               rem_in = 8'(trial - {1'b0, cnt_eff});
            end else begin
               rem_in = trial[7:0];
            end
            quo_in     = {quo_ff[SUM_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff - CNT_W'(1);
            if (div_cnt_ff == CNT_W'(1)) begin
               state_in = B_NET;
            end
         end
         B_NET: begin
            avg_in = avg_q;
            if (tare_ff) begin
               zero_in = avg_q;
            end
            net_in   = $signed({1'b0, avg_q}) - $signed({1'b0, offset});
            state_in = B_MUL;
         end
         B_MUL: begin
            prod_in  = net_ff * scale_factor;
            state_in = B_SAT;
         end
         B_SAT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_sck_in   = 1'b0;
               out_rv_in    = 1'b1;
               out_avg_in   = lcsr_pkg::OUT_AVG_W'(avg_ff);
               out_net_in   = lcsr_pkg::OUT_NET_W'(net_ff);
               out_wgt_in   = wgt_sat;
               out_tare_in  = tare_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         zero_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         zero_ff      <= zero_in;
      end
   end

   // Datapath and output holding registers
   always_ff @(posedge clock) begin
      div_cnt_ff  <= div_cnt_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      tare_ff     <= tare_in;
      avg_ff      <= avg_in;
      net_ff      <= net_in;
      prod_ff     <= prod_in;
      out_sck_ff  <= out_sck_in;
      out_rv_ff   <= out_rv_in;
      out_avg_ff  <= out_avg_in;
      out_net_ff  <= out_net_in;
      out_wgt_ff  <= out_wgt_in;
      out_tare_ff <= out_tare_in;
   end

   assign out_valid        = out_valid_ff;
   assign out_sck          = out_sck_ff;
   assign out_result_valid = out_rv_ff;
   assign out_avg          = out_avg_ff;
   assign out_net          = out_net_ff;
   assign out_weight       = out_wgt_ff;
   assign out_tare         = out_tare_ff;

endmodule

// File: hw/rtl/load_cell_adc_serial_reader.sv
// Top level of the load cell serial reader: register file, front end, queue, back end.
//
//  channel   dir  handshake           payload
//  req_*     in   tvalid/tready       tuser: kind; tdata: dout_level
//  rsp_*     out  tvalid/tready       tuser: result_valid; tdata: sck, avg, net, weight
//  csr_*     in   psel/penable/pready gain, half period, average count, scale
//
// Plain ticks are taken one per cycle while rsp_tready stays high and no average is in the back end.
// A tick that completes an average leaves the queue, then passes through the restoring
// divider and then the tare, multiply and clamp states of the back end.
// The front end keeps taking ticks during that time until the two-entry queue fills.
// Reset is synchronous; it clears the sequencer, sums and tare offset and loads the register reset values.
// The two-entry queue lets ticks enter while a result waits on rsp_tready.
module load_cell_adc_serial_reader #(
   parameter int DATA_BITS = 24,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] dout_level, [7:1] zero
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [lcsr_pkg::RSP_DATA_W-1:0] rsp_tdata, // [0] sck_level, [24:1] average_raw,
                                    // [49:25] net_value, [90:50] weight, [95:91] zero
   output logic        rsp_tuser,   // [0] result_valid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SUM_W   = DATA_BITS + 8;
   localparam int PULSE_W = $clog2(DATA_BITS + 4);
   localparam int JOB_W   = $bits(lcsr_pkg::lcsr_job_ctl_type) + SUM_W;

   logic [1:0]         gain_ff;
   logic [9:0]         half_ff;
   logic [7:0]         avg_cnt_ff;
   logic signed [31:0] scale_ff;
   logic               csr_wr;

   lcsr_pkg::lcsr_job_ctl_type fr_ctl, bk_ctl;
   logic [SUM_W-1:0]   fr_sum, bk_sum;
   logic [JOB_W-1:0]   q_out;
   logic               q_ready, q_valid, q_pop, tick;

   logic               out_sck, out_rv, tare_applied;
   logic [lcsr_pkg::OUT_AVG_W-1:0]        out_avg;
   logic signed [lcsr_pkg::OUT_NET_W-1:0] out_net;
   logic signed [lcsr_pkg::OUT_WGT_W-1:0] out_wgt;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= lcsr_pkg::RST_GAIN;
         half_ff    <= lcsr_pkg::RST_HALF;
         avg_cnt_ff <= lcsr_pkg::RST_AVG;
         scale_ff   <= lcsr_pkg::RST_SCALE;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            lcsr_pkg::REG_GAIN:  gain_ff    <= csr_pwdata[1:0];
            lcsr_pkg::REG_HALF:  half_ff    <= csr_pwdata[9:0];
            lcsr_pkg::REG_AVG:   avg_cnt_ff <= csr_pwdata[7:0];
            lcsr_pkg::REG_SCALE: scale_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_paddr[3:2])
         lcsr_pkg::REG_GAIN:  csr_prdata = {30'd0, gain_ff};
         lcsr_pkg::REG_HALF:  csr_prdata = {22'd0, half_ff};
         lcsr_pkg::REG_AVG:   csr_prdata = {24'd0, avg_cnt_ff};
         lcsr_pkg::REG_SCALE: csr_prdata = scale_ff;
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = q_ready;
   assign tick       = req_tvalid && req_tready;

   lcsr_front #(
      .DATA_BITS (DATA_BITS),
      .SUM_W     (SUM_W),
      .PULSE_W   (PULSE_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .tick              (tick),
      .kind              (req_tuser),
      .dout_level        (req_tdata[0]),
      .gain_mode         (gain_ff),
      .half_period_ticks (half_ff),
      .average_count     (avg_cnt_ff),
      .job_ctl           (fr_ctl),
      .job_sum           (fr_sum)
   );

   lcsr_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tick),
      .push_data ({fr_sum, fr_ctl}),
      .in_ready  (q_ready),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_out)
   );

   assign bk_ctl = q_out[$bits(lcsr_pkg::lcsr_job_ctl_type)-1:0];
   assign bk_sum = q_out[JOB_W-1:$bits(lcsr_pkg::lcsr_job_ctl_type)];

   lcsr_back #(
      .DATA_BITS (DATA_BITS),
      .FRAC_BITS (FRAC_BITS),
      .SUM_W     (SUM_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (q_valid),
      .job_ctl          (bk_ctl),
      .job_sum          (bk_sum),
      .job_pop          (q_pop),
      .average_count    (avg_cnt_ff),
      .scale_factor     (scale_ff),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_sck          (out_sck),
      .out_result_valid (out_rv),
      .out_avg          (out_avg),
      .out_net          (out_net),
      .out_weight       (out_wgt),
      .out_tare         (tare_applied)
   );

   assign rsp_tuser = out_rv;
   assign rsp_tdata = {{lcsr_pkg::RSP_PAD_W{1'b0}}, out_wgt, out_net, out_avg, out_sck};

   // A finished average always lands with the serial clock low
   a_avg_sck_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[0])
      else $error("average result with serial clock high");

   // Plain ticks carry zero result fields
   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[90:1] == 90'd0)
      else $error("plain tick with nonzero result fields");

   // The tared average reads zero net and zero weight
   a_tare_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && tare_applied |-> rsp_tuser && (out_net == '0) && (out_wgt == '0))
      else $error("tared result not zero");

endmodule
